>>> sv/ieqc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ieqc_pkg
// Types and constants shared by the event queue front end, back end and checker.
// ----------------------------------------------------------------------------
package ieqc_pkg;

	// Input actions
	localparam logic [1:0] ACT_SUBMIT_MOUSE = 2'd0;
	localparam logic [1:0] ACT_SUBMIT_KEY   = 2'd1;
	localparam logic [1:0] ACT_POP          = 2'd2;
	localparam logic [1:0] ACT_CLEAR        = 2'd3;

	// Result status codes
	localparam logic [2:0] ST_QUEUED  = 3'd0;
	localparam logic [2:0] ST_DROPPED = 3'd1;
	localparam logic [2:0] ST_IGNORED = 3'd2;
	localparam logic [2:0] ST_POPPED  = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;
	localparam logic [2:0] ST_CLEARED = 3'd5;

	localparam logic [15:0] MOVE_CODE  = 16'h0200;
	localparam logic [31:0] REL_OFFSET = 32'd100000;

	// Stored entry: pay holds extra data for mouse, key data for keyboard
	typedef struct packed {
		logic        kb;
		logic [15:0] code;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] pay;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		CMD_SUBMIT,
		CMD_POP,
		CMD_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		entry_t    ent;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        kb;
		logic [31:0] x;
		logic [31:0] y;
		logic [15:0] code;
		logic [31:0] extra;
		logic [31:0] key;
		logic [7:0]  merged;
		logic        dkb;
		logic        dmove;
		logic [8:0]  count;
	} res_t;

endpackage

>>> sv/input_event_queue_coalescing_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_event_queue_coalescing_unit
// Bounded mouse/keyboard event queue with overflow drop and move coalescing.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | contents
//  s_axis   | in        | tvalid / tready        | request: action in tuser, event in tdata
//  m_axis   | out       | tvalid / tready        | one result per request
//  cfg      | in        | cfg_we (no wait)       | dispatch_enabled
//
//  Pop: moves of the same kind (absolute or relative) that follow a popped move
//  are folded into it. Submit into a full queue: the oldest move is searched for,
//  the entries behind it are shifted down and the new entry goes to the tail;
//  with no move queued, the head entry is dropped instead. The single-port-read
//  entry RAM and the back-end sequencer carry out these steps.
//  Reset is asynchronous; the entry RAM is not cleared. A two-deep command
//  buffer keeps taking requests while a result waits on m_axis.
// ----------------------------------------------------------------------------
module input_event_queue_coalescing_unit #(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// mouse_x[31:0], mouse_y[63:32], mouse_code[79:64], mouse_extra[111:80],
	// key_payload[143:112]
	input  logic [143:0] s_axis_tdata,
	// action[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// out_x[31:0], out_y[63:32], out_code[79:64], out_extra[111:80],
	// out_key[143:112], merged_moves[151:144], dropped_is_keyboard[152],
	// dropped_was_move[153], queue_count[162:154], zero[167:163]
	output logic [167:0] m_axis_tdata,
	// status[2:0], event_is_keyboard[3]
	output logic [3:0]   m_axis_tuser,
	input  logic         cfg_we,
	input  logic         cfg_wdata
);

	ieqc_pkg::cmd_t cmd;
	ieqc_pkg::res_t res;
	logic           cmd_valid, cmd_ready;

	ieqc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser),
		.in_x      (s_axis_tdata[31:0]),
		.in_y      (s_axis_tdata[63:32]),
		.in_code   (s_axis_tdata[79:64]),
		.in_extra  (s_axis_tdata[111:80]),
		.in_key    (s_axis_tdata[143:112]),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	ieqc_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	assign m_axis_tuser = {res.kb, res.status};
	assign m_axis_tdata = {5'd0, res.count, res.dmove, res.dkb, res.merged,
	                       res.key, res.extra, res.code, res.y, res.x};

endmodule

>>> sv/ieqc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ieqc_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ieqc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/ieqc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ieqc_front
// Accepts requests, classifies them into commands and buffers two of them.
// ----------------------------------------------------------------------------
module ieqc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       in_action,
	input  logic [31:0]      in_x,
	input  logic [31:0]      in_y,
	input  logic [15:0]      in_code,
	input  logic [31:0]      in_extra,
	input  logic [31:0]      in_key,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output ieqc_pkg::cmd_t   cmd
);

	ieqc_pkg::cmd_t cls;
	ieqc_pkg::cmd_t buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	// Classify: zero the fields that do not belong to the event kind
	always_comb begin
		cls = '0;
		case (in_action)
			ieqc_pkg::ACT_SUBMIT_MOUSE: begin
				cls.kind     = ieqc_pkg::CMD_SUBMIT;
				cls.ent.x    = in_x;
				cls.ent.y    = in_y;
				cls.ent.code = in_code;
				cls.ent.pay  = in_extra;
			end
			ieqc_pkg::ACT_SUBMIT_KEY: begin
				cls.kind    = ieqc_pkg::CMD_SUBMIT;
				cls.ent.kb  = 1'b1;
				cls.ent.pay = in_key;
			end
			ieqc_pkg::ACT_POP: begin
				cls.kind = ieqc_pkg::CMD_POP;
			end
			default: begin
				cls.kind = ieqc_pkg::CMD_CLEAR;
			end
		endcase
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = buf_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	// Payload buffer
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= cls;
		end
	end

	// Buffer pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> sv/ieqc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ieqc_back
// Executes queue commands on the entry RAM: submit with overflow drop,
// pop with move coalescing, clear, and the dispatch enable register.
// ----------------------------------------------------------------------------
module ieqc_back #(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  ieqc_pkg::cmd_t   cmd,
	output logic             res_valid,
	input  logic             res_ready,
	output ieqc_pkg::res_t   res
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_SRCH_RD, S_SRCH_CHK, S_CMP_RD, S_CMP_WR, S_SUB_WR,
		S_POP_HEAD, S_MRG_RD, S_MRG_CHK, S_MRG_DEC, S_MRG_SUM, S_MRG_ENC, S_FIN
	} state_t;

	state_t          state_q;
	logic            en_q;
	logic [AW-1:0]   head_q, wa_q;
	logic [CW-1:0]   count_q, i_q;

	ieqc_pkg::entry_t ent_q, base_q, nx_q, rdata_e;
	ieqc_pkg::cmd_kind_t kind_q;
	ieqc_pkg::res_t fin_res;
	logic [2:0]  st_q;
	logic [7:0]  merged_q;
	logic        dkb_q, dmv_q;
	logic [31:0] dbx_q, dby_q, dnx_q, dny_q, sx_q, sy_q;

	logic                        ram_we;
	logic [AW-1:0]               ram_wa, ram_ra;
	logic [ieqc_pkg::ENTRY_W-1:0] ram_wd, ram_rd;
	logic [CW+8:0]               cnt_ext;
	logic [CW:0]                 i_p1, i_p2;

	// Ring position of the i-th entry behind the head
	function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] h, input logic [CW-1:0] i);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(i);
		if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
		return s[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] inc_f(input logic [AW-1:0] h);
		return (h == AW'(QUEUE_DEPTH - 1)) ? '0 : h + AW'(1);
	endfunction

	function automatic logic is_move_f(input ieqc_pkg::entry_t e);
		return !e.kb && (e.code == ieqc_pkg::MOVE_CODE);
	endfunction

	function automatic logic rel_ax_f(input logic [31:0] v);
		return v[31] ? ($signed(v) <= -$signed(ieqc_pkg::REL_OFFSET))
		             : ($signed(v) >= $signed(ieqc_pkg::REL_OFFSET));
	endfunction

	function automatic logic is_rel_f(input ieqc_pkg::entry_t e);
		return is_move_f(e) && rel_ax_f(e.x) && rel_ax_f(e.y);
	endfunction

	function automatic logic [31:0] dec_f(input logic [31:0] v);
		return v[31] ? v + ieqc_pkg::REL_OFFSET : v - ieqc_pkg::REL_OFFSET;
	endfunction

	function automatic logic [31:0] sat_f(input logic [32:0] s);
		if (s[32] != s[31]) return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		return s[31:0];
	endfunction

	function automatic logic [31:0] enc_f(input logic [31:0] d);
		logic [32:0] e;
		e = d[31] ? {d[31], d} - {1'b0, ieqc_pkg::REL_OFFSET}
		          : {d[31], d} + {1'b0, ieqc_pkg::REL_OFFSET};
		return sat_f(e);
	endfunction

	ieqc_ram #(.WIDTH(ieqc_pkg::ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.raddr (ram_ra),
		.rdata (ram_rd)
	);

	assign rdata_e   = ieqc_pkg::entry_t'(ram_rd);
	assign i_p1      = (CW+1)'(i_q) + (CW+1)'(1);
	assign i_p2      = (CW+1)'(i_q) + (CW+1)'(2);
	assign cmd_ready = (state_q == S_IDLE) && (!res_valid || res_ready);
	assign cnt_ext   = {9'd0, count_q};

	// RAM port selection
	always_comb begin
		ram_we = 1'b0;
		ram_wa = wa_q;
		ram_wd = ent_q;
		ram_ra = head_q;
		case (state_q)
			S_EXEC: begin
				ram_we = (kind_q == ieqc_pkg::CMD_SUBMIT) && en_q &&
				         (count_q < CW'(QUEUE_DEPTH));
				ram_wa = slot_f(head_q, count_q);
			end
			S_SRCH_RD: ram_ra = slot_f(head_q, i_q);
			S_CMP_RD:  ram_ra = slot_f(head_q, i_p1[CW-1:0]);
			S_CMP_WR: begin
				ram_we = 1'b1;
				ram_wa = slot_f(head_q, i_q);
				ram_wd = ram_rd;
			end
			S_SUB_WR:  ram_we = 1'b1;
			default: ;
		endcase
	end

	// Result fields of the finished command
	always_comb begin
		fin_res        = '0;
		fin_res.status = st_q;
		fin_res.dkb    = dkb_q;
		fin_res.dmove  = dmv_q;
		fin_res.count  = cnt_ext[8:0];
		if (st_q == ieqc_pkg::ST_POPPED) begin
			fin_res.kb     = base_q.kb;
			fin_res.x      = base_q.x;
			fin_res.y      = base_q.y;
			fin_res.code   = base_q.code;
			fin_res.extra  = base_q.kb ? 32'd0 : base_q.pay;
			fin_res.key    = base_q.kb ? base_q.pay : 32'd0;
			fin_res.merged = merged_q;
		end
	end

	// Sequencer: state, queue pointers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			en_q      <= 1'b0;
			head_q    <= '0;
			count_q   <= '0;
			res_valid <= 1'b0;
		end else begin
			if (res_valid && res_ready) res_valid <= 1'b0;
			if (cfg_we) begin
				en_q <= cfg_wdata;
				if (en_q && !cfg_wdata) begin
					head_q  <= '0;
					count_q <= '0;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						kind_q   <= cmd.kind;
						ent_q    <= cmd.ent;
						merged_q <= '0;
						dkb_q    <= 1'b0;
						dmv_q    <= 1'b0;
						i_q      <= '0;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (kind_q)
						ieqc_pkg::CMD_SUBMIT: begin
							if (!en_q) begin
								st_q    <= ieqc_pkg::ST_IGNORED;
								state_q <= S_FIN;
							end else if (count_q < CW'(QUEUE_DEPTH)) begin
								count_q <= count_q + CW'(1);
								st_q    <= ieqc_pkg::ST_QUEUED;
								state_q <= S_FIN;
							end else begin
								st_q    <= ieqc_pkg::ST_DROPPED;
								state_q <= S_SRCH_RD;
							end
						end
						ieqc_pkg::CMD_POP: begin
							if (count_q == '0) begin
								st_q    <= ieqc_pkg::ST_EMPTY;
								state_q <= S_FIN;
							end else begin
								st_q    <= ieqc_pkg::ST_POPPED;
								state_q <= S_POP_HEAD;
							end
						end
						default: begin
							head_q  <= '0;
							count_q <= '0;
							st_q    <= ieqc_pkg::ST_CLEARED;
							state_q <= S_FIN;
						end
					endcase
				end
				// Look for the oldest move in a full queue
				S_SRCH_RD: state_q <= S_SRCH_CHK;
				S_SRCH_CHK: begin
					if ((i_q == '0) && !is_move_f(rdata_e)) dkb_q <= rdata_e.kb;
					if (is_move_f(rdata_e)) begin
						dkb_q <= 1'b0;
						dmv_q <= 1'b1;
						if (i_p1 < (CW+1)'(count_q)) begin
							state_q <= S_CMP_RD;
						end else begin
							wa_q    <= slot_f(head_q, CW'(QUEUE_DEPTH - 1));
							state_q <= S_SUB_WR;
						end
					end else if (i_p1 < (CW+1)'(count_q)) begin
						i_q     <= i_p1[CW-1:0];
						state_q <= S_SRCH_RD;
					end else begin
						// no move queued: the head goes, new entry takes its slot
						wa_q    <= head_q;
						head_q  <= inc_f(head_q);
						state_q <= S_SUB_WR;
					end
				end
				// Close the gap left by the dropped move
				S_CMP_RD: state_q <= S_CMP_WR;
				S_CMP_WR: begin
					i_q <= i_p1[CW-1:0];
					if (i_p2 < (CW+1)'(count_q)) begin
						state_q <= S_CMP_RD;
					end else begin
						wa_q    <= slot_f(head_q, CW'(QUEUE_DEPTH - 1));
						state_q <= S_SUB_WR;
					end
				end
				S_SUB_WR: state_q <= S_FIN;
				// Head of the pop
				S_POP_HEAD: begin
					base_q  <= rdata_e;
					head_q  <= inc_f(head_q);
					count_q <= count_q - CW'(1);
					if (is_move_f(rdata_e) && (count_q != CW'(1))) state_q <= S_MRG_RD;
					else state_q <= S_FIN;
				end
				S_MRG_RD: state_q <= S_MRG_CHK;
				// Decide whether the next entry folds into the popped move
				S_MRG_CHK: begin
					if (!is_move_f(rdata_e) || (is_rel_f(base_q) != is_rel_f(rdata_e))) begin
						state_q <= S_FIN;
					end else begin
						head_q  <= inc_f(head_q);
						count_q <= count_q - CW'(1);
						if (merged_q != 8'hff) merged_q <= merged_q + 8'd1;
						if (is_rel_f(base_q)) begin
							nx_q    <= rdata_e;
							state_q <= S_MRG_DEC;
						end else begin
							base_q  <= rdata_e;
							state_q <= (count_q != CW'(1)) ? S_MRG_RD : S_FIN;
						end
					end
				end
				// Relative merge: decode, add with saturation, re-encode
				S_MRG_DEC: begin
					dbx_q   <= dec_f(base_q.x);
					dby_q   <= dec_f(base_q.y);
					dnx_q   <= dec_f(nx_q.x);
					dny_q   <= dec_f(nx_q.y);
					state_q <= S_MRG_SUM;
				end
				S_MRG_SUM: begin
					sx_q    <= sat_f({dbx_q[31], dbx_q} + {dnx_q[31], dnx_q});
					sy_q    <= sat_f({dby_q[31], dby_q} + {dny_q[31], dny_q});
					state_q <= S_MRG_ENC;
				end
				S_MRG_ENC: begin
					base_q.x <= enc_f(sx_q);
					base_q.y <= enc_f(sy_q);
					state_q  <= (count_q != '0) ? S_MRG_RD : S_FIN;
				end
				// Load the result register
				S_FIN: begin
					res_valid <= 1'b1;
					res       <= fin_res;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> sv/ieqc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ieqc_checker
// Port-level checks on the event queue results, bound to the top level.
// ----------------------------------------------------------------------------
module ieqc_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [167:0] m_axis_tdata,
	input  logic [3:0]   m_axis_tuser
);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// Only defined status codes
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[2:0] != 3'd6 && m_axis_tuser[2:0] != 3'd7)
		else $error("undefined status");

	// Non-pop results carry no event
	a_nopop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2:0] != ieqc_pkg::ST_POPPED
		|-> !m_axis_tuser[3] && m_axis_tdata[151:0] == '0)
		else $error("event fields set on a non-pop result");

	// Drop flags only on a drop, and never both
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[152] || m_axis_tdata[153])
		|-> m_axis_tuser[2:0] == ieqc_pkg::ST_DROPPED
		&& !(m_axis_tdata[152] && m_axis_tdata[153]))
		else $error("drop flags without a drop");

	// Empty and cleared leave no entries
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[2:0] == ieqc_pkg::ST_EMPTY ||
		m_axis_tuser[2:0] == ieqc_pkg::ST_CLEARED) |-> m_axis_tdata[162:154] == 9'd0)
		else $error("entries left after empty or clear");

endmodule

bind input_event_queue_coalescing_unit ieqc_checker u_ieqc_checker (.*);
